>>> hdl/particle_cell_binning_macros.svh
// Assertion macros shared by the particle cell binning design.
`ifndef PARTICLE_CELL_BINNING_MACROS_SVH
`define PARTICLE_CELL_BINNING_MACROS_SVH

// Assert that a condition holds at every rising clock edge outside reset.
`define PCB_ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Assert that expr holds in the next cycle whenever cond is high.
`define PCB_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

>>> hdl/pcb_pkg.sv
// Types and constants of the particle cell binning block.
package pcb_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    localparam logic [2:0] REG_EDGE_X    = 3'd0;
    localparam logic [2:0] REG_EDGE_Y    = 3'd1;
    localparam logic [2:0] REG_EDGE_Z    = 3'd2;
    localparam logic [2:0] REG_NEIGHBOR  = 3'd3;
    localparam logic [2:0] REG_SLOTBYTES = 3'd4;

    typedef struct packed {
        logic        func;
        logic [23:0] x_coord;
        logic [23:0] y_coord;
        logic [23:0] z_coord;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  cell_index;
        logic [5:0]  slot;
        logic [15:0] particle_id;
        logic [6:0]  max_count;
        logic [6:0]  min_count;
        logic [18:0] homecell_bytes;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_IDX,
        S_READ,
        S_UPD,
        S_SCAN,
        S_SCAN_END,
        S_SIZE,
        S_CLEAR,
        S_INIT
    } state_t;

endpackage

>>> hdl/pcb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module pcb_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/pcb_div.sv
// Restoring divider: 16-bit integer coordinate by an 8-bit cell edge, one bit a cycle.
module pcb_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic [15:0] quo_reg, quo_next;
    logic [8:0]  rem_reg, rem_next;
    logic [7:0]  div_reg, div_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic [8:0]  trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    always_comb
    begin
        trial    = {rem_reg[7:0], quo_reg[15]};
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (go)
        begin
            quo_next = dividend;
            rem_next = '0;
            div_next = (divisor == 8'd0) ? 8'd1 : divisor;
            cnt_next = 5'd16;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                run_next = 1'b0;
            end
        end
    end

    assign done     = run_reg && (cnt_reg == 5'd1);
    assign quotient = quo_next;

endmodule

>>> hdl/particle_cell_binning.sv
// Top level of the particle cell binning block.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------
//  item in  | start, busy          | item (pcb_pkg::in_item_t)
//  result   | result_valid strobe  | result (pcb_pkg::out_item_t)
//  config   | APB psel/penable     | paddr, pwdata, prdata
//
// An add beat keeps busy high after the accepting edge through S_DIV (the launch),
// S_IDX (16 divider steps with the three dividers side by side), S_READ (a count
// read) and S_UPD (an update). Its result shows when busy is already low.
// An out-of-range add ends after S_READ, its result showing once busy is low.
// A blocked add gives its result in the next cycle and never raises busy.
// A finish beat walks the count memory, one cell a cycle, and clears it in a
// second pass. Its result is registered in S_SIZE, between the two passes, and
// shows while busy is still high.
// After reset the block clears the count memory, one cell a cycle, holding busy
// high until the last cell is cleared.
// The receiver cannot stall: each result is shown for one cycle.
`include "particle_cell_binning_macros.svh"

module particle_cell_binning #(
    parameter int CELLS_X       = 8,
    parameter int CELLS_Y       = 8,
    parameter int CELLS_Z       = 8,
    parameter int MAX_PER_CELL  = 64,
    parameter int MAX_PARTICLES = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pcb_pkg::in_item_t  item,
    output logic               result_valid,
    output pcb_pkg::out_item_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NCELLS = CELLS_X * CELLS_Y * CELLS_Z;
    localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int PW     = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    // Configuration registers.
    logic [7:0]  edge_x_reg, edge_y_reg, edge_z_reg;
    logic [5:0]  neighbor_reg;
    logic [10:0] slot_bytes_reg;
    logic        cfg_we;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_x_reg     <= 8'd12;
            edge_y_reg     <= 8'd12;
            edge_z_reg     <= 8'd12;
            neighbor_reg   <= 6'd13;
            slot_bytes_reg <= 11'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                pcb_pkg::REG_EDGE_X:    edge_x_reg     <= pwdata[7:0];
                pcb_pkg::REG_EDGE_Y:    edge_y_reg     <= pwdata[7:0];
                pcb_pkg::REG_EDGE_Z:    edge_z_reg     <= pwdata[7:0];
                pcb_pkg::REG_NEIGHBOR:  neighbor_reg   <= pwdata[5:0];
                pcb_pkg::REG_SLOTBYTES: slot_bytes_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            pcb_pkg::REG_EDGE_X:    prdata = {24'd0, edge_x_reg};
            pcb_pkg::REG_EDGE_Y:    prdata = {24'd0, edge_y_reg};
            pcb_pkg::REG_EDGE_Z:    prdata = {24'd0, edge_z_reg};
            pcb_pkg::REG_NEIGHBOR:  prdata = {26'd0, neighbor_reg};
            pcb_pkg::REG_SLOTBYTES: prdata = {21'd0, slot_bytes_reg};
            default:                prdata = '0;
        endcase
    end

    // Control and data registers.
    pcb_pkg::state_t    state_reg, state_next;
    pcb_pkg::in_item_t  item_reg, item_next;
    pcb_pkg::out_item_t res_reg, res_next;
    logic               rv_reg, rv_next;
    logic [PW-1:0]      pcnt_reg, pcnt_next;
    logic               err_reg, err_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      cell_reg, cell_next;
    logic               range_reg, range_next;
    logic [6:0]         max_reg, max_next, min_reg, min_next;
    logic               scan_v_reg, scan_v_next;

    // Dividers, one per axis.
    logic        div_go;
    logic        dx_done, dy_done, dz_done;
    logic [15:0] qx, qy, qz;

    pcb_div u_div_x (.clk(clk), .rst_n(rst_n), .go(div_go), .dividend(item_reg.x_coord[23:8]),
                     .divisor(edge_x_reg), .done(dx_done), .quotient(qx));
    pcb_div u_div_y (.clk(clk), .rst_n(rst_n), .go(div_go), .dividend(item_reg.y_coord[23:8]),
                     .divisor(edge_y_reg), .done(dy_done), .quotient(qy));
    pcb_div u_div_z (.clk(clk), .rst_n(rst_n), .go(div_go), .dividend(item_reg.z_coord[23:8]),
                     .divisor(edge_z_reg), .done(dz_done), .quotient(qz));

    // Count memory.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [6:0]    ram_wdata, ram_rdata;

    pcb_ram #(.WIDTH(7), .DEPTH(NCELLS)) u_counts (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pcb_pkg::S_INIT;
            rv_reg     <= 1'b0;
            pcnt_reg   <= '0;
            err_reg    <= 1'b0;
            addr_reg   <= '0;
            scan_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rv_reg     <= rv_next;
            pcnt_reg   <= pcnt_next;
            err_reg    <= err_next;
            addr_reg   <= addr_next;
            scan_v_reg <= scan_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        cell_reg  <= cell_next;
        range_reg <= range_next;
        max_reg   <= max_next;
        min_reg   <= min_next;
    end

    // Next power of two of a small value, as a shift amount. The sum reaches
    // 128 when the largest count and the neighbor setting are both at the top.
    logic [7:0]  need;
    logic [3:0]  p2_sh;
    logic [18:0] hbytes;

    always_comb
    begin
        need  = {1'b0, max_reg} + {2'b00, neighbor_reg} + 8'd2;
        p2_sh = 4'd7;
        for (int k = 7; k >= 0; k--)
        begin
            if ((8'd1 << k) >= need)
            begin
                p2_sh = k[3:0];
            end
        end
        hbytes = 19'({8'd0, slot_bytes_reg} << p2_sh);
    end

    logic [6:0] inc;
    assign inc = ram_rdata + 7'd1;

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        res_next    = res_reg;
        rv_next     = 1'b0;
        pcnt_next   = pcnt_reg;
        err_next    = err_reg;
        addr_next   = addr_reg;
        cell_next   = cell_reg;
        range_next  = range_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        scan_v_next = 1'b0;
        div_go      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = '0;
        ram_raddr   = addr_reg;
        busy        = 1'b1;

        unique case (state_reg)
            pcb_pkg::S_INIT:
            begin
                ram_we    = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == AW'(NCELLS - 1))
                begin
                    addr_next  = '0;
                    state_next = pcb_pkg::S_IDLE;
                end
            end
            pcb_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    item_next = item;
                    res_next  = '0;
                    res_next.particle_id = 16'(pcnt_reg);
                    if (item.func)
                    begin
                        res_next.status = err_reg ? pcb_pkg::ST_BLOCKED : pcb_pkg::ST_OK;
                        max_next   = 7'd0;
                        min_next   = 7'h7F;
                        addr_next  = '0;
                        state_next = pcb_pkg::S_SCAN;
                    end
                    else if (err_reg)
                    begin
                        res_next.status = pcb_pkg::ST_BLOCKED;
                        rv_next = 1'b1;
                    end
                    else
                    begin
                        state_next = pcb_pkg::S_DIV;
                    end
                end
            end
            pcb_pkg::S_DIV:
            begin
                // The cycle after capture: launch the dividers on the held item.
                div_go     = 1'b1;
                state_next = pcb_pkg::S_IDX;
            end
            pcb_pkg::S_IDX:
            begin
                if (dx_done)
                begin
                    range_next = (qx >= 16'(CELLS_X)) || (qy >= 16'(CELLS_Y))
                              || (qz >= 16'(CELLS_Z));
                    cell_next  = AW'(32'(qx) + 32'(qy) * CELLS_X
                              + 32'(qz) * (CELLS_X * CELLS_Y));
                    state_next = pcb_pkg::S_READ;
                end
            end
            pcb_pkg::S_READ:
            begin
                ram_raddr = cell_reg;
                if (range_reg)
                begin
                    res_next.status = pcb_pkg::ST_RANGE;
                    err_next   = 1'b1;
                    rv_next    = 1'b1;
                    state_next = pcb_pkg::S_IDLE;
                end
                else
                begin
                    state_next = pcb_pkg::S_UPD;
                end
            end
            pcb_pkg::S_UPD:
            begin
                res_next.cell_index = 9'(cell_reg);
                rv_next    = 1'b1;
                state_next = pcb_pkg::S_IDLE;
                if (32'(inc) >= MAX_PER_CELL)
                begin
                    res_next.status = pcb_pkg::ST_FULL;
                    err_next = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_reg;
                    ram_wdata = inc;
                    res_next.slot = ram_rdata[5:0];
                    pcnt_next = (32'(pcnt_reg) == MAX_PARTICLES - 1) ? '0 : pcnt_reg + PW'(1);
                end
            end
            pcb_pkg::S_SCAN:
            begin
                scan_v_next = 1'b1;
                addr_next   = addr_reg + AW'(1);
                if (addr_reg == AW'(NCELLS - 1))
                begin
                    addr_next  = '0;
                    state_next = pcb_pkg::S_SCAN_END;
                end
            end
            pcb_pkg::S_SCAN_END:
            begin
                state_next = pcb_pkg::S_SIZE;
            end
            pcb_pkg::S_SIZE:
            begin
                res_next.max_count      = max_reg;
                res_next.min_count      = min_reg;
                res_next.homecell_bytes = hbytes;
                rv_next    = 1'b1;
                pcnt_next  = '0;
                err_next   = 1'b0;
                state_next = pcb_pkg::S_CLEAR;
            end
            pcb_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == AW'(NCELLS - 1))
                begin
                    addr_next  = '0;
                    state_next = pcb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pcb_pkg::S_IDLE;
            end
        endcase

        // Min and max follow the read data, which lags the scan address by the RAM's registered read.
        if (scan_v_reg)
        begin
            if (ram_rdata > max_reg)
            begin
                max_next = ram_rdata;
            end
            if (ram_rdata < min_reg)
            begin
                min_next = ram_rdata;
            end
        end
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

    `PCB_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy || result_valid)
    `PCB_ASSERT_IMPL(a_strobe_busy, clk, rst_n, !(result_valid && $past(!busy && !start)))
    `PCB_ASSERT_IMPL(a_div_sync, clk, rst_n, (dx_done == dy_done) && (dx_done == dz_done))

endmodule

>>> sim/tb.sv
// Self-checking testbench for the particle cell binning block.
`timescale 1ns / 100ps

module tb;

    // Grid shape and limits; these match the block's default parameters.
    localparam int NX        = 8;
    localparam int NY        = 8;
    localparam int NZ        = 8;
    localparam int NCELLS    = NX * NY * NZ;
    localparam int CELL_CAP  = 64;
    localparam int MAX_CYCLES = 600000;

    // A frame end walks and clears the count memory; the settling after the last
    // beat allows for both passes over the cells and a margin.
    localparam int SETTLE_CYCLES = 2 * NCELLS + 64;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    pcb_pkg::in_item_t  item;
    logic               result_valid;
    pcb_pkg::out_item_t result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    particle_cell_binning u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Local copy of the block's registers and binning state.
    logic [7:0]  edge_x;
    logic [7:0]  edge_y;
    logic [7:0]  edge_z;
    logic [5:0]  neighbor_cnt;
    logic [10:0] slot_size;
    logic [6:0]  occupancy [NCELLS];
    logic [15:0] particle_num;
    logic        bin_error;

    pcb_pkg::out_item_t pending_bins[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Hot cells used to drive cells up to their capacity.
    int          hot_cell [2];

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Run limit; generous compared to the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("particle_cell_binning: mismatch");
            $finish;
        end
    end

    // Cell number along one axis: integer part of the coordinate over the
    // edge length, with an edge of zero acting as one.
    function automatic int unsigned axis_bin(logic [23:0] coord, logic [7:0] edge_len);
        int unsigned whole;
        int unsigned eff;
        whole = 32'(coord[23:8]);
        eff = (edge_len == 8'd0) ? 32'd1 : 32'(edge_len);
        return whole / eff;
    endfunction

    function automatic int unsigned pow2_ceil(int unsigned v);
        int unsigned p;
        p = 1;
        while (p < v)
            p = p << 1;
        return p;
    endfunction

    // Predicts the result of one beat and advances the local state.
    function automatic pcb_pkg::out_item_t bin_particle(pcb_pkg::in_item_t it);
        pcb_pkg::out_item_t r;
        int unsigned sx, sy, sz, idx, cnt, mx, mn;
        r = '0;
        r.particle_id = particle_num;
        if (it.func == 1'b0)
        begin
            if (bin_error)
                r.status = pcb_pkg::ST_BLOCKED;
            else
            begin
                sx = axis_bin(it.x_coord, edge_x);
                sy = axis_bin(it.y_coord, edge_y);
                sz = axis_bin(it.z_coord, edge_z);
                if (sx >= NX || sy >= NY || sz >= NZ)
                begin
                    r.status = pcb_pkg::ST_RANGE;
                    bin_error = 1'b1;
                end
                else
                begin
                    idx = sx + sy * NX + sz * NX * NY;
                    cnt = 32'(occupancy[idx]);
                    r.cell_index = idx[8:0];
                    if (cnt + 1 >= CELL_CAP)
                    begin
                        r.status = pcb_pkg::ST_FULL;
                        bin_error = 1'b1;
                    end
                    else
                    begin
                        occupancy[idx] = 7'(cnt + 1);
                        r.slot = cnt[5:0];
                        particle_num = particle_num + 16'd1;
                    end
                end
            end
        end
        else
        begin
            mx = 0;
            mn = 127;
            for (int i = 0; i < NCELLS; i++)
            begin
                if (32'(occupancy[i]) > mx) mx = 32'(occupancy[i]);
                if (32'(occupancy[i]) < mn) mn = 32'(occupancy[i]);
            end
            r.max_count = mx[6:0];
            r.min_count = mn[6:0];
            r.homecell_bytes = 19'(pow2_ceil(mx + 32'(neighbor_cnt) + 2) * 32'(slot_size));
            r.status = bin_error ? pcb_pkg::ST_BLOCKED : pcb_pkg::ST_OK;
            for (int i = 0; i < NCELLS; i++)
                occupancy[i] = '0;
            particle_num = '0;
            bin_error = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Every result beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        pcb_pkg::out_item_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_bins.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat, actual %p", $time, result);
            end
            else
            begin
                exp_r = pending_bins.pop_front();
                check_field("status", exp_r.status, result.status);
                check_field("cell_index", exp_r.cell_index, result.cell_index);
                check_field("slot", exp_r.slot, result.slot);
                check_field("particle_id", exp_r.particle_id, result.particle_id);
                check_field("max_count", exp_r.max_count, result.max_count);
                check_field("min_count", exp_r.min_count, result.min_count);
                check_field("homecell_bytes", exp_r.homecell_bytes, result.homecell_bytes);
            end
        end
    end

    // Sends one beat. The sender idles with the given chance per cycle, and
    // start stays high across back-to-back beats so there is no forced gap.
    // Busy is looked at mid-cycle, so the beat is taken at the next rising edge.
    task automatic send_item(pcb_pkg::in_item_t it, int idle_pct);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            item = pcb_pkg::in_item_t'({$urandom, $urandom, $urandom});
            @(negedge clk);
        end
        start = 1'b1;
        item = it;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        pending_bins.push_back(bin_particle(it));
    endtask

    // Lowers start and waits for every outstanding result and for the block
    // to go idle.
    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        while (pending_bins.size() != 0 || busy)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write: setup cycle, then the access cycle that commits the register.
    task automatic write_reg(logic [2:0] reg_idx, int unsigned value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (reg_idx)
            pcb_pkg::REG_EDGE_X:    edge_x = value[7:0];
            pcb_pkg::REG_EDGE_Y:    edge_y = value[7:0];
            pcb_pkg::REG_EDGE_Z:    edge_z = value[7:0];
            pcb_pkg::REG_NEIGHBOR:  neighbor_cnt = value[5:0];
            pcb_pkg::REG_SLOTBYTES: slot_size = value[10:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(int unsigned ex, int unsigned ey, int unsigned ez,
                             int unsigned nb, int unsigned sb);
        drain();
        write_reg(pcb_pkg::REG_EDGE_X, ex);
        write_reg(pcb_pkg::REG_EDGE_Y, ey);
        write_reg(pcb_pkg::REG_EDGE_Z, ez);
        write_reg(pcb_pkg::REG_NEIGHBOR, nb);
        write_reg(pcb_pkg::REG_SLOTBYTES, sb);
    endtask

    function automatic pcb_pkg::in_item_t add_at(int unsigned ix, int unsigned iy,
                                                 int unsigned iz);
        pcb_pkg::in_item_t it;
        it.func = 1'b0;
        it.x_coord = {ix[15:0], 8'($urandom)};
        it.y_coord = {iy[15:0], 8'($urandom)};
        it.z_coord = {iz[15:0], 8'($urandom)};
        return it;
    endfunction

    function automatic pcb_pkg::in_item_t finish_frame;
        pcb_pkg::in_item_t it;
        it = pcb_pkg::in_item_t'({$urandom, $urandom, $urandom});
        it.func = 1'b1;
        return it;
    endfunction

    // Integer coordinate that lands in a chosen cell along one axis.
    function automatic int unsigned coord_in_bin(int unsigned bin, logic [7:0] edge_len);
        int unsigned eff;
        eff = (edge_len == 8'd0) ? 32'd1 : 32'(edge_len);
        return bin * eff + $urandom_range(eff - 1);
    endfunction

    // Field extremes, every operation, range error, blocked add and a
    // frame end with the error latched, all at the reset settings.
    task automatic test_directed;
        pcb_pkg::in_item_t it;
        send_item(add_at(0, 0, 0), 0);
        send_item(add_at(0, 0, 0), 0);
        send_item(add_at(95, 95, 95), 0);
        send_item(add_at(95, 0, 95), 0);
        send_item(finish_frame(), 0);
        it = '0;
        send_item(it, 0);
        send_item(finish_frame(), 0);
        it = '1;
        it.func = 1'b0;
        send_item(it, 0);
        send_item(add_at(1, 1, 1), 0);
        send_item(finish_frame(), 0);
        send_item(add_at(96, 0, 0), 0);
        send_item(finish_frame(), 0);
        send_item(add_at(0, 96, 0), 0);
        send_item(finish_frame(), 0);
        send_item(add_at(0, 0, 96), 0);
        it = '1;
        send_item(it, 0);
    endtask

    // A zero edge acts as one, and zero slot bytes gives a zero size.
    task automatic test_zero_settings;
        configure(0, 0, 0, 63, 0);
        send_item(add_at(7, 7, 7), 0);
        send_item(add_at(3, 5, 0), 0);
        send_item(add_at(8, 0, 0), 0);
        send_item(finish_frame(), 0);
        send_item(add_at(2, 2, 2), 0);
        send_item(finish_frame(), 0);
    endtask

    // Random traffic. Most adds land inside the grid; with hot set, most go to
    // two cells so that cells fill up. A few beats carry raw random fields.
    task automatic test_random(int count, int idle_pct, bit hot, bit pause_once);
        pcb_pkg::in_item_t it;
        int unsigned c, roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (pause_once && n == count / 2)
                drain();
            if (roll < 2)
                it = finish_frame();
            else if (roll < 7)
            begin
                it = pcb_pkg::in_item_t'({$urandom, $urandom, $urandom});
                it.func = 1'b0;
            end
            else
            begin
                if (hot && roll < 80)
                    c = hot_cell[$urandom_range(1)];
                else
                    c = $urandom_range(NCELLS - 1);
                it = add_at(coord_in_bin(c % NX, edge_x),
                            coord_in_bin((c / NX) % NY, edge_y),
                            coord_in_bin(c / (NX * NY), edge_z));
            end
            send_item(it, idle_pct);
        end
    endtask

    initial
    begin
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        edge_x = 8'd12;
        edge_y = 8'd12;
        edge_z = 8'd12;
        neighbor_cnt = 6'd13;
        slot_size = 11'd64;
        particle_num = '0;
        bin_error = 1'b0;
        for (int i = 0; i < NCELLS; i++)
            occupancy[i] = '0;
        hot_cell[0] = $urandom_range(NCELLS - 1);
        hot_cell[1] = $urandom_range(NCELLS - 1);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_zero_settings();
        configure(1, 1, 1, 0, 1);
        test_random(180, 0, 1'b0, 1'b0);
        configure(255, 255, 255, 63, 1024);
        test_random(180, 65, 1'b1, 1'b0);
        configure($urandom_range(1, 255), $urandom_range(1, 255),
                  $urandom_range(1, 255), $urandom_range(63), $urandom_range(1, 1024));
        test_random(180, 10, 1'b1, 1'b0);
        configure(12, 12, 12, 13, 64);
        test_random(180, 0, 1'b1, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_bins.size() == 0)
            $display("particle_cell_binning: match");
        else
            $display("particle_cell_binning: mismatch");
        $finish;
    end

endmodule
